### design/q8_block_dequantizer_macros.svh
// Assertion macros used by the checker file.
`ifndef Q8_BLOCK_DEQUANTIZER_MACROS_SVH
`define Q8_BLOCK_DEQUANTIZER_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define Q8_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define Q8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/q8bd_pkg.sv
// ----------------------------------------------------------------------------
// q8bd_pkg
// Constants and helper functions of the 8-bit block dequantizer.
// ----------------------------------------------------------------------------
package q8bd_pkg;

    localparam int unsigned BLOCK_BYTES    = 34;
    localparam int unsigned MAX_ROW_BLOCKS = 4096;
    localparam int unsigned CFG_W          = 13;
    localparam logic [7:0]  EXP_BIAS_DIFF  = 8'd112;   // 127 - 15
    localparam logic [31:0] QNAN_DEFAULT   = 32'h7FC0_0000;

    // Register indexes
    localparam logic [0:0]  REG_BLOCKS_PER_ROW = 1'b0;

    // Widen a half-precision value to single precision.
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic        s;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  lz;
        logic [10:0] m;
        logic [7:0]  e;
        logic [31:0] res;
        s   = h[15];
        ex  = h[14:10];
        man = h[9:0];
        lz  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                lz = 4'(9 - i);
            end
        end
        m = 11'(man) << (lz + 4'd1);
        e = EXP_BIAS_DIFF + 8'd1 - 8'(lz) - 8'd1;
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                res = {s, 31'd0};
            end else begin
                res = {s, e, m[9:0], 13'd0};
            end
        end else if (ex == 5'h1F) begin
            res = {s, 8'hFF, man, 13'd0};
        end else begin
            res = {s, 8'(ex) + EXP_BIAS_DIFF, man, 13'd0};
        end
        return res;
    endfunction

endpackage

### design/q8_block_dequantizer.sv
// ----------------------------------------------------------------------------
// q8_block_dequantizer
// Turns 34-byte blocks (half scale plus 32 int8 quants) into single words.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  input   | i_valid, o_stall, i_data_byte            | in
//  output  | o_valid, i_stall, o_value_bits, flags    | out
//  config  | APB psel/penable/pwrite/paddr/pwdata      | in
//
// One byte per cycle is accepted while o_stall is low; each quant byte's result
// registers in the next cycle. The byte and held scale feed one 24-bit by 8-bit multiply
// and a normalize step into the result register. A stalled result holds and stalls
// the input only while the result register is full. Reset clears all control state.
module q8_block_dequantizer #(
    parameter int unsigned MAX_ROW_BLOCKS = q8bd_pkg::MAX_ROW_BLOCKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value_bits,
    output logic [4:0]  o_element_index,
    output logic        o_last_of_block,
    output logic        o_last_of_row,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned BIR_W = (MAX_ROW_BLOCKS > 1) ? $clog2(MAX_ROW_BLOCKS) : 1;
    localparam int unsigned LIM_W = $clog2(MAX_ROW_BLOCKS + 1);

    logic [q8bd_pkg::CFG_W-1:0] r_blocks_per_row;
    logic [5:0]  r_byte_position, n_byte_position;
    logic [7:0]  r_scale_low;
    logic [31:0] r_scale, n_scale;
    logic [BIR_W-1:0] r_block_in_row, n_block_in_row;
    logic        r_valid;
    logic        accept, emit;
    logic [LIM_W-1:0] limit;
    logic        last_blk, last_row;
    logic [31:0] value;

    assign pready  = 1'b1;
    assign prdata  = {{(32-q8bd_pkg::CFG_W){1'b0}}, r_blocks_per_row};
    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;

    // Clamp the row length.
    always_comb begin
        if (r_blocks_per_row == '0) begin
            limit = LIM_W'(1);
        end else if (32'(r_blocks_per_row) > MAX_ROW_BLOCKS) begin
            limit = LIM_W'(MAX_ROW_BLOCKS);
        end else begin
            limit = LIM_W'(r_blocks_per_row);
        end
    end

    // Advance the block position.
    always_comb begin
        logic [5:0] pos;
        pos = (r_byte_position >= 6'(q8bd_pkg::BLOCK_BYTES)) ? 6'd0 : r_byte_position;
        n_scale         = r_scale;
        n_block_in_row  = r_block_in_row;
        last_blk        = (pos == 6'(q8bd_pkg::BLOCK_BYTES - 1));
        last_row        = 1'b0;
        emit            = (pos > 6'd1);
        n_byte_position = pos + 6'd1;
        if (pos == 6'd1) begin
            n_scale = q8bd_pkg::widen_half({i_data_byte, r_scale_low});
        end
        if (last_blk) begin
            n_byte_position = 6'd0;
            if (32'(r_block_in_row) + 32'd1 >= 32'(limit)) begin
                last_row       = 1'b1;
                n_block_in_row = '0;
            end else begin
                n_block_in_row = r_block_in_row + BIR_W'(1);
            end
        end
    end

    // Multiply the scale by the quant and normalize.
    always_comb begin
        logic       qneg, sgn;
        logic [7:0] qmag, ex;
        logic [31:0] m;
        logic [2:0] top;
        qneg = i_data_byte[7];
        qmag = qneg ? (8'd0 - i_data_byte) : i_data_byte;
        sgn  = r_scale[31] ^ qneg;
        ex   = r_scale[30:23];
        m    = 32'({1'b1, r_scale[22:0]}) * 32'(qmag);
        top  = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (m[23+i]) begin
                top = 3'(i);
            end
        end
        if (ex == 8'hFF) begin
            if (r_scale[22:0] != '0) begin
                value = r_scale | 32'h0040_0000;
            end else if (qmag == 8'd0) begin
                value = q8bd_pkg::QNAN_DEFAULT;
            end else begin
                value = {sgn, 8'hFF, 23'd0};
            end
        end else if (qmag == 8'd0 || r_scale[30:0] == '0) begin
            value = {sgn, 31'd0};
        end else begin
            m     = m >> top;
            value = {sgn, ex + 8'(top), m[22:0]};
        end
    end

    // Hold state and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_per_row <= q8bd_pkg::CFG_W'(1);
            r_byte_position  <= '0;
            r_scale_low      <= '0;
            r_scale          <= '0;
            r_block_in_row   <= '0;
            r_valid          <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == q8bd_pkg::REG_BLOCKS_PER_ROW
                && paddr[1:0] == 2'd0) begin
                r_blocks_per_row <= pwdata[q8bd_pkg::CFG_W-1:0];
            end
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            if (accept) begin
                r_byte_position <= n_byte_position;
                r_scale         <= n_scale;
                r_block_in_row  <= n_block_in_row;
                if (n_byte_position == 6'd1) begin
                    r_scale_low <= i_data_byte;
                end
                if (emit) begin
                    r_valid <= 1'b1;
                end
            end
        end
    end

    // Load the result payload.
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            o_value_bits    <= value;
            o_element_index <= 5'(r_byte_position - 6'd2);
            o_last_of_block <= last_blk;
            o_last_of_row   <= last_row;
        end
    end

endmodule

### design/q8bd_checker.sv
// ----------------------------------------------------------------------------
// q8bd_checker
// Port-level checks of the 8-bit block dequantizer.
// ----------------------------------------------------------------------------
`include "q8_block_dequantizer_macros.svh"
module q8bd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [4:0] o_element_index,
    input logic       o_last_of_block,
    input logic       o_last_of_row
);
    // Flags and index agree.
    `Q8_ASSERT_SAME(a_last_blk, i_clk, i_rst_n, o_valid, o_last_of_block == (o_element_index == 5'd31))
    // Row end only at a block end.
    `Q8_ASSERT_SAME(a_row_blk, i_clk, i_rst_n, o_valid && o_last_of_row, o_last_of_block)
    // Never stall the input while the output is empty.
    `Q8_ASSERT_SAME(a_no_stall, i_clk, i_rst_n, !o_valid, !o_stall)
    // A held result keeps its index.
    `Q8_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_element_index))
endmodule

bind q8_block_dequantizer q8bd_checker u_q8bd_checker (.*);

### tb/sv/q8_block_dequantizer_tb.sv
// ----------------------------------------------------------------------------
// q8_block_dequantizer_tb
// Streams 34-byte quantized blocks into the dequantizer under random input
// gaps and output stalls, predicts every single-precision word and its block
// and row flags, and compares each output word field by field. The row
// length register is rewritten between phases, the extremes among them.
// ----------------------------------------------------------------------------
module q8_block_dequantizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [4:0]  element_index;
        logic        last_of_block;
        logic        last_of_row;
    } t_deq_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_value_bits;
    logic [4:0]  o_element_index;
    logic        o_last_of_block;
    logic        o_last_of_row;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    q8_block_dequantizer dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state
    logic [12:0] row_len_reg = 13'd1;
    int unsigned byte_pos = 0;
    logic [7:0]  scale_lo = 8'd0;
    logic [31:0] scale_sp = 32'd0;
    int unsigned blk_in_row = 0;

    logic [7:0]  pending_bytes[$];
    t_deq_word   expected_words[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    function automatic logic [31:0] half_to_single(logic [15:0] h);
        logic [31:0] sgn;
        logic [9:0]  man;
        logic [10:0] m;
        int          e;
        sgn = {h[15], 31'd0};
        man = h[9:0];
        if (h[14:10] == 5'd0) begin
            if (man == 10'd0) return sgn;
            m = {1'b0, man};
            e = 113;
            while (!m[10]) begin
                m = m << 1;
                e--;
            end
            return sgn | (32'(e) << 23) | (32'(m[9:0]) << 13);
        end
        if (h[14:10] == 5'h1F) return sgn | 32'h7F80_0000 | (32'(man) << 13);
        return sgn | ((32'(h[14:10]) + 32'd112) << 23) | (32'(man) << 13);
    endfunction

    function automatic logic [31:0] scaled_quant(logic [31:0] s, logic [7:0] q);
        logic [31:0] sgn;
        logic [7:0]  mag;
        logic [7:0]  ex;
        logic [31:0] m;
        int          top;
        mag = q[7] ? 8'(-q) : q;
        sgn = {s[31] ^ q[7], 31'd0};
        ex = s[30:23];
        if (ex == 8'hFF) begin
            if (s[22:0] != 0) return s | 32'h0040_0000;
            if (mag == 0) return q8bd_pkg::QNAN_DEFAULT;
            return sgn | 32'h7F80_0000;
        end
        if (q == 8'd128) mag = 8'd128;
        if (q == 8'd0 || (ex == 0 && s[22:0] == 0)) return sgn;
        m = ({9'd1, s[22:0]}) * {24'd0, mag};
        top = 23;
        while (top < 31 && (m >> (top + 1)) != 0) top++;
        m = m >> (top - 23);
        return sgn | (32'(ex + 8'(top - 23)) << 23) | (m & 32'h7F_FFFF);
    endfunction

    // Advance the predictor by one accepted byte.
    task automatic predict_byte(logic [7:0] b);
        int unsigned limit;
        t_deq_word   w;
        if (byte_pos >= 34) byte_pos = 0;
        if (byte_pos == 0) begin
            scale_lo = b;
            byte_pos = 1;
        end else if (byte_pos == 1) begin
            scale_sp = half_to_single({b, scale_lo});
            byte_pos = 2;
        end else begin
            limit = row_len_reg;
            if (limit == 0) limit = 1;
            if (limit > q8bd_pkg::MAX_ROW_BLOCKS) limit = q8bd_pkg::MAX_ROW_BLOCKS;
            w.value_bits = scaled_quant(scale_sp, b);
            w.element_index = 5'(byte_pos - 2);
            w.last_of_block = (byte_pos == 33);
            w.last_of_row = 1'b0;
            if (byte_pos == 33) begin
                if (blk_in_row + 1 >= limit) begin
                    w.last_of_row = 1'b1;
                    blk_in_row = 0;
                end else begin
                    blk_in_row++;
                end
                byte_pos = 0;
            end else begin
                byte_pos++;
            end
            expected_words.push_back(w);
        end
    endtask

    // Drive the next byte; hold it while stalled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_byte(i_data_byte);
            end
            if (!i_valid || !o_stall) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_data_byte <= pending_bytes.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the output at random, or for a long hold-off.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted word with the oldest prediction.
    always @(posedge i_clk) begin
        t_deq_word w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word 0x%08h", o_value_bits);
                fail_count++;
            end else begin
                w = expected_words.pop_front();
                if (o_value_bits !== w.value_bits) begin
                    $error("value_bits exp 0x%08h got 0x%08h", w.value_bits, o_value_bits);
                    fail_count++;
                end
                if (o_element_index !== w.element_index) begin
                    $error("element_index exp %0d got %0d", w.element_index, o_element_index);
                    fail_count++;
                end
                if (o_last_of_block !== w.last_of_block) begin
                    $error("last_of_block exp %0b got %0b", w.last_of_block, o_last_of_block);
                    fail_count++;
                end
                if (o_last_of_row !== w.last_of_row) begin
                    $error("last_of_row exp %0b got %0b", w.last_of_row, o_last_of_row);
                    fail_count++;
                end
            end
        end
    end

    // Write one register through the APB port.
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'(q8bd_pkg::REG_BLOCKS_PER_ROW) * 4) row_len_reg = data[12:0];
    endtask

    task automatic drain_stream();
        while (pending_bytes.size() > 0 || i_valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic queue_block(logic [15:0] scale, int mode);
        pending_bytes.push_back(scale[7:0]);
        pending_bytes.push_back(scale[15:8]);
        for (int k = 0; k < 32; k++) begin
            case (mode)
                0: pending_bytes.push_back(8'($urandom));
                1: pending_bytes.push_back(k[0] ? 8'h80 : 8'h7F);
                default: pending_bytes.push_back(k[0] ? 8'h00 : 8'hFF);
            endcase
        end
    endtask

    function automatic logic [15:0] random_scale();
        case ($urandom_range(7))
            0: return {1'($urandom_range(1)), 5'd0, 10'($urandom)};
            1: return {1'($urandom_range(1)), 5'h1F, 10'($urandom_range(1) ? 0 : $urandom)};
            2: return {1'($urandom_range(1)), 15'd0};
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] directed_scales[8];
        int          row_lens[6];
        directed_scales = '{16'h3C00, 16'h0000, 16'h8000, 16'h0001, 16'h7C00,
                            16'hFC00, 16'h7E01, 16'hFBFF};
        row_lens = '{0, 3, 8191, 1, 4096, 2};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed scales and quant extremes at the reset row length
        foreach (directed_scales[n]) queue_block(directed_scales[n], n % 3);
        drain_stream();
        // Ignored register index, then a row length change mid-row
        write_reg(3'd4, 32'd5);
        queue_block(16'h3555, 0);
        drain_stream();
        write_reg(3'd0, 32'd3);
        drain_stream();
        queue_block(16'h4000, 0);
        queue_block(16'h4000, 0);
        drain_stream();
        write_reg(3'd0, 32'd1);
        drain_stream();

        // Long hold-off: the block fills and stalls its input
        for (int n = 0; n < 4; n++) queue_block(random_scale(), 0);
        hold_cycles = 300;
        drain_stream();

        for (int p = 0; p < 6; p++) begin
            write_reg(3'd0, 32'(row_lens[p]));
            case (p % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 45; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 45; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            // Whole blocks with random scales
            for (int n = 0; n < 6; n++) queue_block(random_scale(), 0);
            drain_stream();
        end
        // A partial block left pending across the final idle
        for (int k = 0; k < 5; k++) pending_bytes.push_back(8'($urandom));
        drain_stream();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

### q8_block_dequantizer.f
+incdir+design
design/q8bd_pkg.sv
design/q8_block_dequantizer.sv
design/q8bd_checker.sv
tb/sv/q8_block_dequantizer_tb.sv
